// ===== hw/rtl/sha1_pkg.sv =====
// SHA-1 hasher package: working-state type, initial hash values, round constants.
// Shared by sha1_round and sha1_message_hasher_core; no dependencies.
package sha1_pkg;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } work_t;

  localparam int unsigned Rounds    = 80;
  localparam int unsigned RoundW    = 7;
  localparam int unsigned DigWords  = 5;
  localparam int unsigned BlockBits = 512;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // digest word index codes
  localparam logic [2:0] WORD_FIRST = 3'd0;
  localparam logic [2:0] WORD_LAST  = 3'd4;

  // input kind codes
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] r;
    case (idx)
      3'd0:    r = IV0;
      3'd1:    r = IV1;
      3'd2:    r = IV2;
      3'd3:    r = IV3;
      default: r = IV4;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/sha1_round.sv =====
// SHA-1 round unit: one compression round, shared over all 80 rounds.
// Depends on sha1_pkg (work_t, round constants).
module sha1_round (
  input  sha1_pkg::work_t                    work_i,
  input  logic [31:0]                        w_i,
  input  logic [sha1_pkg::RoundW-1:0]        round_i,
  output sha1_pkg::work_t                    work_o
);

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] rot_a;

  always_comb begin
    if (round_i < sha1_pkg::RoundW'(20)) begin
      f = (work_i.b & work_i.c) | (~work_i.b & work_i.d);
      k = sha1_pkg::K0;
    end else if (round_i < sha1_pkg::RoundW'(40)) begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = sha1_pkg::K1;
    end else if (round_i < sha1_pkg::RoundW'(60)) begin
      f = (work_i.b & work_i.c) | (work_i.b & work_i.d) | (work_i.c & work_i.d);
      k = sha1_pkg::K2;
    end else begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = sha1_pkg::K3;
    end
  end

  assign rot_a = {work_i.a[26:0], work_i.a[31:27]};

  always_comb begin
    work_o.a = rot_a + f + work_i.e + k + w_i;
    work_o.b = work_i.a;
    work_o.c = {work_i.b[1:0], work_i.b[31:2]};
    work_o.d = work_i.c;
    work_o.e = work_i.d;
  end

endmodule

// ===== hw/rtl/sha1_message_hasher_core.sv =====
// SHA-1 message hasher top level: byte intake, padding sequencer, schedule, digest out.
// Depends on sha1_pkg and sha1_round.
//
// Usage:
//   Input stream (s_axis): tuser = 0 carries one message byte in tdata; tuser = 1 is a
//   finish transfer (tdata ignored) that pads the message and starts the digest.
//   Output stream (m_axis): five transfers per finish, digest word in tdata (most
//   significant word first), word index in tuser, tlast on the fifth word.
// Sequence:
//   A data byte is accepted in ST_IDLE. The 64th byte of a block starts compression (80
//   rounds on the shared round unit, then a fold into the chaining state); s_axis_tready_o
//   is low meanwhile.
//   A finish shifts in the pad bytes one per cycle, compresses, and when the length does
//   not fit repeats with a full pad block; then the five digest words are offered, one per
//   cycle at best.
// Reset: chaining state returns to the initial hash values, counts clear, block idle.
// The same cleanup happens after the fifth digest word is taken, so the next message
// starts directly. A stalled receiver holds the current word; nothing else advances.
module sha1_message_hasher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] kind
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser_o,   // [2:0] word_index
  output logic        m_axis_tlast_o    // last_word
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_e;

  localparam int unsigned Bw = sha1_pkg::BlockBits;

  state_e                       state_q, state_d;
  logic [5:0]                   fill_q, fill_d;      // bytes in current block
  logic [60:0]                  count_q, count_d;    // message bytes, wraps
  logic [31:0]                  chain_q [sha1_pkg::DigWords];
  logic [31:0]                  chain_d [sha1_pkg::DigWords];
  logic [Bw-1:0]                msg_q, msg_d;        // block / schedule window
  sha1_pkg::work_t              work_q, work_d;
  logic [sha1_pkg::RoundW-1:0]  round_q, round_d;
  logic                         finishing_q, finishing_d;
  logic                         len_here_q, len_here_d; // length goes in this block
  logic                         pad_first_q, pad_first_d;
  logic [2:0]                   out_idx_q, out_idx_d;

  sha1_pkg::work_t              work_next;
  logic                         s_fire;
  logic                         m_fire;
  logic                         push;
  logic [7:0]                   push_byte;
  logic [7:0]                   pad_byte;
  logic [63:0]                  len_shift;
  logic [31:0]                  w_new;
  logic [31:0]                  w_x;
  sha1_pkg::work_t              chain_w;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_OUT);
  assign m_axis_tdata_o  = chain_q[out_idx_q];
  assign m_axis_tuser_o  = out_idx_q;
  assign m_axis_tlast_o  = (out_idx_q == sha1_pkg::WORD_LAST);

  assign s_fire = s_axis_tvalid_i & s_axis_tready_o;
  assign m_fire = m_axis_tvalid_o & m_axis_tready_i;

  // Bit length, big-endian: byte (fill - 56) of {count, 3'b0}.
  assign len_shift = {count_q, 3'b000} << {fill_q[2:0], 3'b000};

  always_comb begin
    if (pad_first_q) begin
      pad_byte = sha1_pkg::PAD_BYTE;
    end else if (len_here_q && (fill_q >= 6'd56)) begin
      pad_byte = len_shift[63:56];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Schedule: window holds W[t..t+15], W[t] in the top word.
  assign w_x   = msg_q[Bw-1 -: 32] ^ msg_q[Bw-1-2*32 -: 32] ^
                 msg_q[Bw-1-8*32 -: 32] ^ msg_q[Bw-1-13*32 -: 32];
  assign w_new = {w_x[30:0], w_x[31]};

  assign chain_w.a = chain_q[0];
  assign chain_w.b = chain_q[1];
  assign chain_w.c = chain_q[2];
  assign chain_w.d = chain_q[3];
  assign chain_w.e = chain_q[4];

  sha1_round u_round (
    .work_i  (work_q),
    .w_i     (msg_q[Bw-1 -: 32]),
    .round_i (round_q),
    .work_o  (work_next)
  );

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    count_d     = count_q;
    chain_d     = chain_q;
    msg_d       = msg_q;
    work_d      = work_q;
    round_d     = round_q;
    finishing_d = finishing_q;
    len_here_d  = len_here_q;
    pad_first_d = pad_first_q;
    out_idx_d   = out_idx_q;
    push        = 1'b0;
    push_byte   = s_axis_tdata_i;

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          if (s_axis_tuser_i == sha1_pkg::KIND_FINISH) begin
            state_d     = ST_PAD;
            finishing_d = 1'b1;
            pad_first_d = 1'b1;
            len_here_d  = (fill_q < 6'd56);
          end else begin
            push    = 1'b1;
            count_d = count_q + 61'd1;
          end
        end
      end
      ST_PAD: begin
        push        = 1'b1;
        push_byte   = pad_byte;
        pad_first_d = 1'b0;
      end
      ST_ROUND: begin
        work_d  = work_next;
        msg_d   = {msg_q[Bw-33:0], w_new};
        round_d = round_q + sha1_pkg::RoundW'(1);
        if (round_q == sha1_pkg::RoundW'(sha1_pkg::Rounds - 1)) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        chain_d[0] = chain_q[0] + work_q.a;
        chain_d[1] = chain_q[1] + work_q.b;
        chain_d[2] = chain_q[2] + work_q.c;
        chain_d[3] = chain_q[3] + work_q.d;
        chain_d[4] = chain_q[4] + work_q.e;
        if (!finishing_q) begin
          state_d = ST_IDLE;
        end else if (len_here_q) begin
          state_d   = ST_OUT;
          out_idx_d = sha1_pkg::WORD_FIRST;
        end else begin
          // length did not fit; one more block of zeros and length
          len_here_d = 1'b1;
          state_d    = ST_PAD;
        end
      end
      ST_OUT: begin
        if (m_fire) begin
          out_idx_d = out_idx_q + 3'd1;
          if (out_idx_q == sha1_pkg::WORD_LAST) begin
            state_d     = ST_IDLE;
            finishing_d = 1'b0;
            count_d     = '0;
            fill_d      = '0;
            for (int i = 0; i < sha1_pkg::DigWords; i++) begin
              chain_d[i] = sha1_pkg::iv_word(3'(i));
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (push) begin
      msg_d  = {msg_q[Bw-9:0], push_byte};
      fill_d = fill_q + 6'd1;
      if (fill_q == 6'd63) begin
        // block full: start compression from the chaining state
        state_d = ST_ROUND;
        round_d = '0;
        work_d  = chain_w;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      count_q     <= '0;
      round_q     <= '0;
      finishing_q <= 1'b0;
      len_here_q  <= 1'b0;
      pad_first_q <= 1'b0;
      out_idx_q   <= sha1_pkg::WORD_FIRST;
      for (int i = 0; i < sha1_pkg::DigWords; i++) begin
        chain_q[i] <= sha1_pkg::iv_word(3'(i));
      end
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      count_q     <= count_d;
      round_q     <= round_d;
      finishing_q <= finishing_d;
      len_here_q  <= len_here_d;
      pad_first_q <= pad_first_d;
      out_idx_q   <= out_idx_d;
      chain_q     <= chain_d;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    msg_q  <= msg_d;
    work_q <= work_d;
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench for sha1_message_hasher_core: byte streams and finish transfers are
// checked word by word against a built-in SHA-1 digest predictor.
// Depends on sha1_pkg and the core RTL; needs no files or arguments.
module tb_top;

  localparam int unsigned ItemTarget  = 500;
  localparam int unsigned CycleLimit  = 2_000_000;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned MaxReports  = 10;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  // SHA-1 predictor plus the queue of digest words it expects
  class digest_checker;
    logic [31:0]  chain[5];
    logic [7:0]   blk[64];
    int unsigned  fill;
    logic [60:0]  byte_count;
    digest_word_t expected_words[$];
    int unsigned  mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      chain[0]   = sha1_pkg::IV0;
      chain[1]   = sha1_pkg::IV1;
      chain[2]   = sha1_pkg::IV2;
      chain[3]   = sha1_pkg::IV3;
      chain[4]   = sha1_pkg::IV4;
      fill       = 0;
      byte_count = '0;
    endfunction

    // 80-round compression of blk into the chaining state
    function void fold_block();
      logic [31:0] w[80];
      logic [31:0] a, b, c, d, e, f, k, t, x;
      int i;
      for (i = 0; i < 16; i++) begin
        w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      end
      for (i = 16; i < 80; i++) begin
        x    = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
        w[i] = {x[30:0], x[31]};
      end
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (i = 0; i < 80; i++) begin
        if (i < 20) begin
          f = (b & c) | (~b & d);
          k = sha1_pkg::K0;
        end else if (i < 40) begin
          f = b ^ c ^ d;
          k = sha1_pkg::K1;
        end else if (i < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = sha1_pkg::K2;
        end else begin
          f = b ^ c ^ d;
          k = sha1_pkg::K3;
        end
        t = {a[26:0], a[31:27]} + f + e + k + w[i];
        e = d;
        d = c;
        c = {b[1:0], b[31:2]};
        b = a;
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    // called once per accepted input transfer
    function void note_transfer(input logic kind, input logic [7:0] data);
      logic [63:0]  bit_len;
      digest_word_t dw;
      int i;
      if (kind == sha1_pkg::KIND_DATA) begin
        blk[fill] = data;
        fill++;
        byte_count++;
        if (fill == 64) begin
          fold_block();
          fill = 0;
        end
      end else begin
        bit_len   = {byte_count, 3'b000};
        blk[fill] = sha1_pkg::PAD_BYTE;
        fill++;
        // length field does not fit: close this block, pad a fresh one
        if (fill > 56) begin
          while (fill < 64) begin
            blk[fill] = 8'h00;
            fill++;
          end
          fold_block();
          fill = 0;
        end
        while (fill < 56) begin
          blk[fill] = 8'h00;
          fill++;
        end
        for (i = 0; i < 8; i++) begin
          blk[56+i] = bit_len[63-8*i -: 8];
        end
        fold_block();
        for (i = 0; i < sha1_pkg::DigWords; i++) begin
          dw.word = chain[i];
          dw.idx  = 3'(i);
          dw.last = (i == sha1_pkg::DigWords - 1);
          expected_words.push_back(dw);
        end
        restart();
      end
    endfunction

    // called once per accepted output transfer
    function void check_word(input logic [31:0] word, input logic [2:0] idx,
                             input logic last);
      digest_word_t exp_w;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("unexpected digest word %h idx %0d last %b", word, idx, last);
        end
      end else begin
        exp_w = expected_words.pop_front();
        if (exp_w.word !== word || exp_w.idx !== idx || exp_w.last !== last) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("digest mismatch: expected %h idx %0d last %b, got %h idx %0d last %b",
                     exp_w.word, exp_w.idx, exp_w.last, word, idx, last);
          end
        end
      end
    endfunction
  endclass

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        s_tvalid  = 1'b0;
  logic [7:0]  s_tdata   = 8'h00;
  logic        s_tuser   = sha1_pkg::KIND_DATA;
  logic        m_tready  = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  digest_checker board;
  int unsigned   burst_left = 0;
  int unsigned   items_sent = 0;
  int unsigned   cycles     = 0;
  int unsigned   rx_cycle   = 0;
  int unsigned   rx_mode    = 0;

  sha1_message_hasher_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: checks accepted words, then picks next tready from a randomly redrawn
  // mode (always ready, coin flip, sparse, periodic stall)
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      board.check_word(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
    end
    rx_cycle++;
    if (rx_cycle % 40 == 0) begin
      rx_mode = $urandom_range(0, 3);
    end
    case (rx_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      2:       m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= (rx_cycle % 16 == 15);
    endcase
  end

  // one input transfer; the sender runs in bursts with idle gaps between them
  task automatic send_transfer(input logic kind, input logic [7:0] data);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    board.note_transfer(kind, data);
    items_sent++;
    burst_left--;
  endtask

  // random-content message of len bytes followed by a finish
  task automatic send_message(input int unsigned len);
    int unsigned n;
    for (n = 0; n < len; n++) begin
      send_transfer(sha1_pkg::KIND_DATA, 8'($urandom_range(0, 255)));
    end
    send_transfer(sha1_pkg::KIND_FINISH, 8'($urandom_range(0, 255)));
  endtask

  // lengths biased toward the padding boundaries (55/56 bytes fit or not,
  // 63/64 fill a block exactly)
  function automatic int unsigned pick_length();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      return $urandom_range(0, 24);
    end else if (sel < 8) begin
      case ($urandom_range(0, 9))
        0:       return 55;
        1:       return 56;
        2:       return 57;
        3:       return 63;
        4:       return 64;
        5:       return 65;
        6:       return 119;
        7:       return 120;
        8:       return 127;
        default: return 128;
      endcase
    end else if (sel == 8) begin
      return $urandom_range(0, 200);
    end else begin
      return $urandom_range(0, 1);
    end
  endfunction

  initial begin
    board = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty message, ignored tdata at both extremes, back to back
    send_transfer(sha1_pkg::KIND_FINISH, 8'hFF);
    send_transfer(sha1_pkg::KIND_FINISH, 8'h00);
    // "abc"
    send_transfer(sha1_pkg::KIND_DATA, 8'h61);
    send_transfer(sha1_pkg::KIND_DATA, 8'h62);
    send_transfer(sha1_pkg::KIND_DATA, 8'h63);
    send_transfer(sha1_pkg::KIND_FINISH, 8'h5A);
    // byte extremes and a data byte equal to the pad marker
    send_transfer(sha1_pkg::KIND_DATA, 8'h00);
    send_transfer(sha1_pkg::KIND_DATA, 8'hFF);
    send_transfer(sha1_pkg::KIND_DATA, sha1_pkg::PAD_BYTE);
    send_transfer(sha1_pkg::KIND_FINISH, 8'hA5);

    while (items_sent < ItemTarget) begin
      send_message(pick_length());
    end
    s_tvalid <= 1'b0;

    while (board.expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
